// ===== rtl/bdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debouncer with long-press events.
// ----------------------------------------------------------------------------
package bdlp_pkg;

   // Debounce threshold, in ticks, for the 8-bit and 3-bit counters
   localparam logic [7:0] DEBOUNCE_TICKS   = 8'd5;
   localparam logic [2:0] DEBOUNCE_TICKS_3 = 3'd5;

   // CSR register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PRESSED_LEVEL  = 2'd0,
      CSR_RELEASE_ENABLE = 2'd1,
      CSR_LONG_PRESS     = 2'd2
   } csr_index_type;

   // Reported event codes
   typedef enum logic [1:0] {
      EVT_NONE     = 2'd0,
      EVT_PRESSED  = 2'd1,
      EVT_RELEASED = 2'd2,
      EVT_LONG     = 2'd3
   } event_code_type;

   // Internal debouncer outcome of one sample
   typedef enum logic [2:0] {
      SMP_NONE,
      SMP_EDGE,
      SMP_SETTLE_ON,
      SMP_SETTLE_OFF,
      SMP_LONG
   } sample_event_type;

   typedef struct packed {
      logic       pressed_level;
      logic       release_enable;
      logic [7:0] long_press_ticks;
   } cfg_type;

   typedef struct packed {
      event_code_type event_code;
      logic [7:0]     press_duration;
      logic           button_down;
   } result_type;

endpackage

// ===== rtl/bdlp_ifs.sv =====
// ----------------------------------------------------------------------------
// bdlp_ifs
// Valid/ready channel interfaces for pin samples and debounce results.
// ----------------------------------------------------------------------------
interface bdlp_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink   (input valid, input pin_level, output ready);
endinterface

interface bdlp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_code;
   logic [7:0] press_duration;
   logic       button_down;

   modport source (output valid, output event_code, output press_duration,
                   output button_down, input ready);
   modport sink   (input valid, input event_code, input press_duration,
                   input button_down, output ready);
endinterface

// ===== rtl/bdlp_cfg.sv =====
// ----------------------------------------------------------------------------
// bdlp_cfg
// Configuration registers written through the CSR write port.
// ----------------------------------------------------------------------------
module bdlp_cfg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [bdlp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bdlp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output bdlp_pkg::cfg_type                    cfg
);
   import bdlp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PRESSED_LEVEL:  cfg_in.pressed_level    = csr_wdata[0];
            CSR_RELEASE_ENABLE: cfg_in.release_enable   = csr_wdata[0];
            CSR_LONG_PRESS:     cfg_in.long_press_ticks = csr_wdata;
            default:            cfg_in = cfg_ff;   // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressed_level    <= 1'b0;
         cfg_ff.release_enable   <= 1'b1;
         cfg_ff.long_press_ticks <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/bdlp_core.sv =====
// ----------------------------------------------------------------------------
// bdlp_core
// Debounce and press state; one sample step per asserted step_en.
// ----------------------------------------------------------------------------
module bdlp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  bdlp_pkg::cfg_type    cfg,
   input  logic                 step_en,
   input  logic                 pin_level,
   output bdlp_pkg::result_type result
);
   import bdlp_pkg::*;

   logic       down_ff,     down_in;
   logic       watch_ff,    watch_in;
   logic       settled_ff,  settled_in;
   logic       last_ff,     last_in;
   logic [7:0] active_ff,   active_in;
   logic [2:0] inactive_ff, inactive_in;
   logic [7:0] held_ff,     held_in;

   sample_event_type smp;
   logic [7:0]       active_inc;
   logic [2:0]       inactive_inc;

   assign active_inc   = active_ff + 8'd1;
   assign inactive_inc = inactive_ff + 3'd1;

   // Debouncer: edge detect, settle counting, long-press counting
   always_comb begin
      smp         = SMP_NONE;
      active_in   = active_ff;
      inactive_in = inactive_ff;
      settled_in  = settled_ff;
      if (settled_ff) begin
         if (pin_level == watch_ff && last_ff != watch_ff) begin
            smp         = SMP_EDGE;
            active_in   = 8'd0;
            inactive_in = 3'd0;
            settled_in  = 1'b0;
         end else if (pin_level != watch_ff && watch_ff != cfg.pressed_level) begin
            inactive_in = 3'd0;
            active_in   = active_inc;
            if (cfg.long_press_ticks != 8'd0 && active_inc >= cfg.long_press_ticks) begin
               active_in = 8'd0;
               smp       = SMP_LONG;
            end
         end
      end else if (pin_level == watch_ff) begin
         inactive_in = 3'd0;
         active_in   = active_inc;
         if (active_inc >= DEBOUNCE_TICKS) begin
            settled_in = 1'b1;
            smp        = SMP_SETTLE_ON;
         end
      end else begin
         active_in   = 8'd0;
         inactive_in = inactive_inc;
         if (inactive_inc >= DEBOUNCE_TICKS_3) begin
            settled_in = 1'b1;
            smp        = SMP_SETTLE_OFF;
         end
      end
      last_in = pin_level;
   end

   // Press state and event reporting
   always_comb begin
      down_in               = down_ff;
      watch_in              = watch_ff;
      held_in               = held_ff;
      result.event_code     = EVT_NONE;
      result.press_duration = 8'd0;
      if (!down_ff) begin
         if (smp == SMP_EDGE) begin
            result.event_code = EVT_PRESSED;
            held_in           = 8'd0;
            down_in           = 1'b1;
         end
      end else begin
         unique case (smp)
            SMP_NONE: held_in = held_ff + 8'd1;
            SMP_SETTLE_ON: watch_in = ~watch_ff;
            SMP_SETTLE_OFF: begin
               watch_in = cfg.pressed_level;
               down_in  = 1'b0;
            end
            SMP_EDGE: begin
               if (cfg.release_enable) begin
                  result.event_code     = EVT_RELEASED;
                  result.press_duration = held_ff;
               end
               watch_in = cfg.pressed_level;
               down_in  = 1'b0;
            end
            SMP_LONG: result.event_code = EVT_LONG;
            default: result.event_code = EVT_NONE;
         endcase
      end
      result.button_down = down_in;
   end

   // Reset values follow the reset value of pressed_level (low)
   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff     <= 1'b0;
         watch_ff    <= 1'b0;
         settled_ff  <= 1'b1;
         last_ff     <= 1'b1;
         active_ff   <= 8'd0;
         inactive_ff <= 3'd0;
         held_ff     <= 8'd0;
      end else if (step_en) begin
         down_ff     <= down_in;
         watch_ff    <= watch_in;
         settled_ff  <= settled_in;
         last_ff     <= last_in;
         active_ff   <= active_in;
         inactive_ff <= inactive_in;
         held_ff     <= held_in;
      end
   end

   // While settling, both counters stay under the threshold
   a_settle_bound: assert property (@(posedge clock) disable iff (reset)
      !settled_ff |-> (active_ff < DEBOUNCE_TICKS && inactive_ff < DEBOUNCE_TICKS_3))
      else $error("settle counter passed threshold while unsettled");

   // A pressed event leaves the block in the down state
   a_press_down: assert property (@(posedge clock) disable iff (reset)
      (step_en && result.event_code == EVT_PRESSED) |=> down_ff)
      else $error("pressed event without entering down state");

   // Duration is only reported with a release
   a_dur_release: assert property (@(posedge clock) disable iff (reset)
      (step_en && result.press_duration != 8'd0) |-> result.event_code == EVT_RELEASED)
      else $error("press duration outside a release event");

   // Long press only while down and not leaving
   a_long_down: assert property (@(posedge clock) disable iff (reset)
      (step_en && result.event_code == EVT_LONG) |-> (down_ff && result.button_down))
      else $error("long press reported while released");

endmodule

// ===== rtl/button_debounce_long_press.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Debouncer for a sampled button pin with press, release and long-press events.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one pin sample per request (pin_level); each request is
//   one debounce tick. rsp_bus returns exactly one response per request:
//   event_code (none / pressed / released / long press), press_duration
//   (held ticks, nonzero only on a release) and button_down.
//   csr_* writes pressed_level, release_enable and long_press_ticks; write
//   them only while no request is in flight.
// Timing:
//   A request is held in the input register; the state update and the
//   response register load at the edge where the response register is free,
//   which raises rsp valid. One request per cycle is sustained while rsp
//   ready stays high; the input register and the response register are the
//   two stages.
// Reset:
//   Synchronous, active high. Clears both stages, the CSRs to their defaults
//   and the debounce state to released/settled.
// Back-pressure:
//   A stalled rsp holds its data; the input register still takes one more
//   request, then req ready drops until the response is taken.
// ----------------------------------------------------------------------------
module button_debounce_long_press (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [bdlp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bdlp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   bdlp_req_if.sink                          req_bus,
   bdlp_rsp_if.source                        rsp_bus
);
   import bdlp_pkg::*;

   cfg_type    cfg;
   result_type step_result;

   // input stage
   logic s0_valid_ff, s0_valid_in;
   logic s0_level_ff;

   // response stage
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   logic out_free;   // response register can load this cycle
   logic step_en;    // input stage advances into the response stage
   logic req_take;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign step_en  = s0_valid_ff && out_free;
   assign req_bus.ready = !s0_valid_ff || out_free;
   assign req_take = req_bus.valid && req_bus.ready;

   assign s0_valid_in  = req_take ? 1'b1 : (step_en ? 1'b0 : s0_valid_ff);
   assign rsp_valid_in = step_en ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   bdlp_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bdlp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step_en   (step_en),
      .pin_level (s0_level_ff),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_level_ff <= req_bus.pin_level;
      end
      if (step_en) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.event_code     = rsp_data_ff.event_code;
   assign rsp_bus.press_duration = rsp_data_ff.press_duration;
   assign rsp_bus.button_down    = rsp_data_ff.button_down;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button debouncer: directed press, release and
// long-press sequences, then random bouncy gestures under CSR settings that
// change between phases, with idle bursts on both channels and a long
// response hold-off. Every response is checked field by field against an
// in-bench model of the debounce state machine or a typed-in directed row.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bdlp_pkg::*;

   localparam int unsigned LIMIT_CYCLES   = 400000;
   localparam int unsigned RANDOM_ITEMS   = 1900;
   localparam int unsigned QUIET_AFTER    = 1650;   // no idling past this many requests
   localparam int unsigned HOLD_CYCLES    = 150;    // long response hold-off
   localparam int unsigned SETTLE_CYCLES  = 4;      // pipeline is 2 deep
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // One row of the directed table: a CSR write or a pin sample, the latter
   // optionally with its response typed in
   typedef struct {
      logic                   is_csr;
      logic [CSR_INDEX_W-1:0] csr_addr;
      logic [CSR_DATA_W-1:0]  csr_data;
      logic                   pin;
      logic                   typed;
      result_type             want;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   bdlp_req_if req_ch ();
   bdlp_rsp_if rsp_ch ();

   button_debounce_long_press dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch)
   );

   // Debouncer model: CSRs and state
   cfg_type    cfg;
   logic       m_down;      // pressed state
   logic       m_watch;     // level watched for an edge
   logic       m_settled;
   logic       m_last;      // previous pin level
   logic [7:0] m_run;       // debounce / long-press counter
   logic [2:0] m_quiet;     // ticks away from the watched level
   logic [7:0] m_held;      // quiet ticks while pressed

   result_type pending_results[$];   // expected responses, oldest first

   int unsigned  errors;
   int unsigned  sent_count;
   int unsigned  seen_count;
   int unsigned  press_count;
   int unsigned  release_count;
   int unsigned  long_count;
   int unsigned  phase_count;
   int unsigned  input_stalls;
   int unsigned  cycle_count;
   bit           quiet;       // end of run: no idling on either side
   bit           hold_rsp;    // asks the receiver for a long hold-off
   result_type   oldest;
   plan_row_type plan[];

   initial begin
      forever #4 clock = ~clock;
   end

   // One tick of the debouncer; updates the model state
   function automatic result_type debounce_tick(input logic pin);
      sample_event_type ev;
      result_type       r;
      ev = SMP_NONE;
      r  = '{EVT_NONE, 8'd0, 1'b0};
      if (m_settled) begin
         if (pin == m_watch && m_last != m_watch) begin
            ev        = SMP_EDGE;
            m_run     = '0;
            m_quiet   = '0;
            m_settled = 1'b0;
         end else if (pin != m_watch && m_watch != cfg.pressed_level) begin
            // steady press: counts toward a long press, wraps at 8 bits
            m_quiet = '0;
            m_run   = m_run + 8'd1;
            if (cfg.long_press_ticks != 0 && m_run >= cfg.long_press_ticks) begin
               m_run = '0;
               ev    = SMP_LONG;
            end
         end
      end else if (pin == m_watch) begin
         m_quiet = '0;
         m_run   = m_run + 8'd1;
         if (m_run >= DEBOUNCE_TICKS) begin
            m_settled = 1'b1;
            ev        = SMP_SETTLE_ON;
         end
      end else begin
         m_run   = '0;
         m_quiet = m_quiet + 3'd1;
         if (m_quiet >= DEBOUNCE_TICKS_3) begin
            m_settled = 1'b1;
            ev        = SMP_SETTLE_OFF;
         end
      end
      m_last = pin;

      if (!m_down) begin
         // settling and long-press outcomes are dropped while released
         if (ev == SMP_EDGE) begin
            r.event_code = EVT_PRESSED;
            m_held       = '0;
            m_down       = 1'b1;
         end
      end else begin
         case (ev)
            SMP_NONE: begin
               m_held = m_held + 8'd1;
            end
            SMP_SETTLE_ON: begin
               m_watch = ~m_watch;
            end
            SMP_SETTLE_OFF: begin
               m_watch = cfg.pressed_level;
               m_down  = 1'b0;
            end
            SMP_EDGE: begin
               if (cfg.release_enable) begin
                  r.event_code     = EVT_RELEASED;
                  r.press_duration = m_held;
               end
               m_watch = cfg.pressed_level;
               m_down  = 1'b0;
            end
            default: begin
               r.event_code = EVT_LONG;
            end
         endcase
      end
      r.button_down = m_down;
      return r;
   endfunction

   function automatic plan_row_type row_sample(input logic pin);
      plan_row_type row;
      row = '{1'b0, '0, '0, pin, 1'b0, '{EVT_NONE, 8'd0, 1'b0}};
      return row;
   endfunction

   function automatic plan_row_type row_check(input logic pin, input event_code_type ev,
                                              input logic [7:0] dur, input logic down);
      plan_row_type row;
      row = '{1'b0, '0, '0, pin, 1'b1, '{ev, dur, down}};
      return row;
   endfunction

   function automatic plan_row_type row_csr(input logic [CSR_INDEX_W-1:0] addr,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type row;
      row = '{1'b1, addr, data, 1'b0, 1'b0, '{EVT_NONE, 8'd0, 1'b0}};
      return row;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, expected %0d (response %0d, cycle %0d)",
               what, got, want, seen_count, cycle_count);
      errors++;
   endtask

   // Offer one pin sample, maybe after an idle burst; predict once accepted
   task automatic send_sample(input logic pin, input logic typed, input result_type want);
      result_type predicted;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(0, 13)) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.pin_level <= pin;
      do @(posedge clock); while (!req_ch.ready);
      predicted = debounce_tick(pin);
      pending_results.push_back(typed ? want : predicted);
      sent_count++;
   endtask

   // Stop offering and wait until every response is back and the pipe is empty
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= addr;
      csr_wdata <= data;
      @(posedge clock);
      case (addr)
         CSR_PRESSED_LEVEL:  cfg.pressed_level    = data[0];
         CSR_RELEASE_ENABLE: cfg.release_enable   = data[0];
         CSR_LONG_PRESS:     cfg.long_press_ticks = data[7:0];
         default: ;   // unmapped index, write dropped
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Zero to three pairs of a short run of one level and a short opposite-level run (contact bounce)
   task automatic bounce(input logic level);
      repeat ($urandom_range(0, 3)) begin
         repeat ($urandom_range(1, 3)) send_sample(level, 1'b0, '0);
         repeat ($urandom_range(1, 3)) send_sample(~level, 1'b0, '0);
      end
   endtask

   // Bouncy press, hold (rarely past the 8-bit wrap), bouncy release, idle
   task automatic press_gesture();
      logic on;
      int   hold;
      on   = cfg.pressed_level;
      hold = ($urandom_range(0, 14) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 40);
      bounce(on);
      repeat (hold) send_sample(on, 1'b0, '0);
      bounce(~on);
      repeat ($urandom_range(0, 12)) send_sample(~on, 1'b0, '0);
   endtask

   // Response side: random stall bursts, one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Response checker and watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_results.size());
         $display("button_debounce_long_press test failed");
         $finish;
      end
      if (!reset) begin
         if (req_ch.valid && !req_ch.ready) input_stalls++;
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_count++;
            case (rsp_ch.event_code)
               EVT_PRESSED:  press_count++;
               EVT_RELEASED: release_count++;
               EVT_LONG:     long_count++;
               default: ;
            endcase
            if (pending_results.size() == 0) begin
               report_mismatch("response with nothing expected", rsp_ch.event_code, -1);
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_ch.event_code !== oldest.event_code)
                  report_mismatch("event_code", rsp_ch.event_code, oldest.event_code);
               if (rsp_ch.press_duration !== oldest.press_duration)
                  report_mismatch("press_duration", rsp_ch.press_duration,
                                  oldest.press_duration);
               if (rsp_ch.button_down !== oldest.button_down)
                  report_mismatch("button_down", rsp_ch.button_down, oldest.button_down);
            end
         end
      end
   end

   // Stimulus
   initial begin
      req_ch.valid     = 1'b0;
      req_ch.pin_level = 1'b0;

      // model state after reset
      cfg.pressed_level    = 1'b0;
      cfg.release_enable   = 1'b1;
      cfg.long_press_ticks = 8'd0;
      m_down    = 1'b0;
      m_watch   = 1'b0;
      m_settled = 1'b1;
      m_last    = 1'b1;
      m_run     = '0;
      m_quiet   = '0;
      m_held    = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Defaults first: pressed is low, release reporting on,
      // long press off.
      plan = '{
         row_check(1'b0, EVT_PRESSED, 8'd0, 1'b1),     // first edge right after reset
         row_sample(1'b0), row_sample(1'b0), row_sample(1'b0), row_sample(1'b0),
         row_sample(1'b0),                              // 5th steady tick settles
         row_sample(1'b0), row_sample(1'b0),
         row_check(1'b1, EVT_RELEASED, 8'd6, 1'b0),    // duration counts quiet ticks
         row_sample(1'b1), row_sample(1'b1), row_sample(1'b1), row_sample(1'b1),
         row_sample(1'b1),                              // settles released
         // shortest long press, release reporting off
         row_csr(CSR_LONG_PRESS, 8'd1),
         row_csr(CSR_RELEASE_ENABLE, 8'd0),
         row_check(1'b0, EVT_PRESSED, 8'd0, 1'b1),
         row_sample(1'b0), row_sample(1'b0), row_sample(1'b0), row_sample(1'b0),
         row_sample(1'b0),
         row_check(1'b0, EVT_LONG, 8'd0, 1'b1),
         row_check(1'b0, EVT_LONG, 8'd0, 1'b1),
         row_check(1'b1, EVT_NONE, 8'd0, 1'b0),        // silent release
         // flip the pressed level mid-state; state keeps its values
         row_csr(CSR_PRESSED_LEVEL, 8'hFF),
         row_csr(CSR_LONG_PRESS, 8'hFF),
         row_csr(CSR_RELEASE_ENABLE, 8'hFF),
         row_csr(CSR_UNUSED_INDEX, 8'h5A),              // ignored
         row_sample(1'b1), row_sample(1'b0)
      };
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            drain();
            csr_write(plan[i].csr_addr, plan[i].csr_data);
         end else begin
            send_sample(plan[i].pin, plan[i].typed, plan[i].want);
         end
      end

      // Random part: phases of gestures, CSRs rewritten between phases
      while (sent_count < RANDOM_ITEMS) begin
         drain();   // sender pauses until all responses are back
         phase_count++;
         csr_write(CSR_PRESSED_LEVEL, 8'($urandom_range(0, 255)));
         csr_write(CSR_RELEASE_ENABLE, 8'($urandom_range(0, 255)));
         case ($urandom_range(0, 5))
            0:       csr_write(CSR_LONG_PRESS, 8'd0);
            1:       csr_write(CSR_LONG_PRESS, 8'd1);
            2:       csr_write(CSR_LONG_PRESS, 8'd255);
            default: csr_write(CSR_LONG_PRESS, 8'($urandom_range(2, 40)));
         endcase
         if ($urandom_range(0, 3) == 0)
            csr_write(CSR_UNUSED_INDEX, 8'($urandom_range(0, 255)));

         // one phase runs against a stalled response channel so the pipe fills
         if (phase_count == 3) hold_rsp = 1'b1;

         repeat ($urandom_range(2, 5)) begin
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 20))
                  send_sample(1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
               press_gesture();
            end
            if (sent_count >= QUIET_AFTER) quiet = 1'b1;
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("responses never returned", 0, pending_results.size());

      $display("ran %0d pin samples over %0d CSR phases; %0d responses checked",
               sent_count, phase_count, seen_count);
      $display("events seen: %0d press, %0d release, %0d long press; input stalled %0d cycles",
               press_count, release_count, long_count, input_stalls);
      if (errors == 0) begin
         $display("button_debounce_long_press test passed");
      end else begin
         $display("button_debounce_long_press test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bdlp_pkg.sv
rtl/bdlp_ifs.sv
rtl/bdlp_cfg.sv
rtl/bdlp_core.sv
rtl/button_debounce_long_press.sv
bench/tb.sv
